// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of the encoder block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, outside reset.
`define QED_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle, outside reset.
`define QED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle, checked during reset too.
`define QED_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/qed_pkg.sv -----
// Package with the item types, event codes and register indexes of the encoder block.
`default_nettype none

package qed_pkg;

  localparam logic [1:0] TURN_NONE = 2'd0;
  localparam logic [1:0] TURN_CW   = 2'd1;
  localparam logic [1:0] TURN_CCW  = 2'd2;

  localparam logic [1:0] PRESS_NONE    = 2'd0;
  localparam logic [1:0] PRESS_PRESS   = 2'd1;
  localparam logic [1:0] PRESS_RELEASE = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ROT_LOCKOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BTN_LOCKOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MASK = 2'd2;

  localparam logic [CFG_DATA_W-1:0] ROT_LOCKOUT_RST = 16'd5;
  localparam logic [CFG_DATA_W-1:0] BTN_LOCKOUT_RST = 16'd50;
  localparam logic [CFG_DATA_W-1:0] TARGET_MASK_RST = 16'd0;

  typedef struct packed {
    logic        phase_a;
    logic        phase_b;
    logic        button_level;
    logic [31:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic [1:0]         turn_event;
    logic [1:0]         press_event;
    logic signed [31:0] count;
    logic               held;
    logic [15:0]        event_mask;
  } result_t;

  typedef struct packed {
    logic [1:0]  last_phase;
    logic        primed;
    logic [31:0] step_count;
    logic [31:0] last_turn_time;
    logic [31:0] last_press_time;
    logic        pressed;
  } state_t;

endpackage

`default_nettype wire

// ----- src/qed_chan_if.sv -----
// Valid/ready channel interface carrying one item of a given payload type.
`default_nettype none

interface qed_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/qed_step.sv -----
// Combinational update of the decoder state and the result for one pin sample.
`default_nettype none

module qed_step (
  input  qed_pkg::sample_t smp,
  input  qed_pkg::state_t  cur,
  input  logic [15:0]      rot_lockout,
  input  logic [15:0]      btn_lockout,
  input  logic [15:0]      target_mask,
  output qed_pkg::state_t  nxt,
  output qed_pkg::result_t res
);

  // Position of a phase pair along the clockwise Gray cycle 00, 01, 11, 10.
  function automatic logic [1:0] gray_index(input logic [1:0] ph);
    logic [1:0] idx;
    case (ph)
      2'b00:   idx = 2'd0;
      2'b01:   idx = 2'd1;
      2'b11:   idx = 2'd2;
      2'b10:   idx = 2'd3;
      default: idx = 2'd0;
    endcase
    return idx;
  endfunction

  logic [1:0]  phase;
  logic        press_now;
  logic [31:0] turn_elapsed;
  logic [31:0] press_elapsed;
  logic [1:0]  delta;
  logic [1:0]  turn;
  logic [1:0]  press;

  assign phase         = {smp.phase_a, smp.phase_b};
  assign press_now     = ~smp.button_level;
  assign turn_elapsed  = smp.now_ms - cur.last_turn_time;
  assign press_elapsed = smp.now_ms - cur.last_press_time;
  assign delta         = gray_index(phase) - gray_index(cur.last_phase);

  always_comb begin
    nxt   = cur;
    turn  = qed_pkg::TURN_NONE;
    press = qed_pkg::PRESS_NONE;
    if (!cur.primed) begin
      nxt.last_phase = phase;
      nxt.primed     = 1'b1;
    end else begin
      // A changed pair inside the lockout leaves even the stored phase alone.
      if ((phase != cur.last_phase) && (turn_elapsed >= {16'd0, rot_lockout})) begin
        if (delta == 2'd1) begin
          nxt.step_count     = cur.step_count + 32'd1;
          nxt.last_turn_time = smp.now_ms;
          turn               = qed_pkg::TURN_CW;
        end else if (delta == 2'd3) begin
          nxt.step_count     = cur.step_count - 32'd1;
          nxt.last_turn_time = smp.now_ms;
          turn               = qed_pkg::TURN_CCW;
        end
        nxt.last_phase = phase;
      end
      if ((press_elapsed >= {16'd0, btn_lockout}) && (press_now != cur.pressed)) begin
        nxt.pressed         = press_now;
        nxt.last_press_time = smp.now_ms;
        press               = press_now ? qed_pkg::PRESS_PRESS : qed_pkg::PRESS_RELEASE;
      end
    end
  end

  always_comb begin
    res.turn_event  = turn;
    res.press_event = press;
    res.count       = signed'(nxt.step_count);
    res.held        = nxt.pressed;
    res.event_mask  = target_mask;
  end

endmodule

`default_nettype wire

// ----- src/quadrature_encoder_debounce.sv -----
// Top level of the quadrature encoder decoder with button debounce.
`default_nettype none

// Takes one pin sample per clock while results are taken, and returns one result item
// per sample. An accepted sample waits in the input register; the state update and
// result are computed from it combinationally and are loaded into the result register
// once that register is empty or its item is taken. Throughput is one item per clock
// whenever the consumer takes results; a stalled result holds in the output register
// while the sample behind it waits in the input register. The user must write the
// lockout and mask registers through the cfg port only while no item is in flight;
// the block does not enforce it. A write to an index beyond the target mask is ignored.
module quadrature_encoder_debounce (
  input  logic                               clk,
  input  logic                               rst_n,
  qed_chan_if.sink                           in_ch,
  qed_chan_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [qed_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qed_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic                      s1_valid_r;
  qed_pkg::sample_t          s1_data_r;
  logic                      out_valid_r;
  qed_pkg::result_t          out_data_r;
  qed_pkg::state_t           state_r;
  qed_pkg::state_t           state_nxt;
  qed_pkg::result_t          res_nxt;
  logic [15:0]               rot_lockout_r;
  logic [15:0]               btn_lockout_r;
  logic [15:0]               target_mask_r;
  logic                      s2_load;
  logic                      in_fire;

  assign s2_load      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s2_load;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  qed_step u_step (
    .smp         (s1_data_r),
    .cur         (state_r),
    .rot_lockout (rot_lockout_r),
    .btn_lockout (btn_lockout_r),
    .target_mask (target_mask_r),
    .nxt         (state_nxt),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s2_load) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_load) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_ch.data;
    end
    if (s2_load) begin
      out_data_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_lockout_r <= qed_pkg::ROT_LOCKOUT_RST;
      btn_lockout_r <= qed_pkg::BTN_LOCKOUT_RST;
      target_mask_r <= qed_pkg::TARGET_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        qed_pkg::CFG_ROT_LOCKOUT: rot_lockout_r <= cfg_data;
        qed_pkg::CFG_BTN_LOCKOUT: btn_lockout_r <= cfg_data;
        qed_pkg::CFG_TARGET_MASK: target_mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/qed_checker.sv -----
// Port-level checker for the encoder block and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module qed_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input qed_pkg::result_t out_data
);

  // A result that is not taken must stay offered unchanged.
  `QED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result item changed or vanished")

  // A press event must leave the debounced state pressed.
  `QED_ASSERT_SAME(a_press_held, clk, rst_n, out_valid && (out_data.press_event == qed_pkg::PRESS_PRESS), out_data.held, "press item without held state")

  // A release event must leave the debounced state released.
  `QED_ASSERT_SAME(a_release_free, clk, rst_n, out_valid && (out_data.press_event == qed_pkg::PRESS_RELEASE), !out_data.held, "release item with held state")

  // Reset empties the result register.
  `QED_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid, "result item valid after reset")

endmodule

bind quadrature_encoder_debounce qed_checker u_qed_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire

// ----- verif/tb_quadrature_encoder_debounce.sv -----
// Self-checking testbench for the quadrature encoder decoder with button debounce.

// Tracks the decoder state, predicts one result item per accepted sample and checks results.
class encoder_scoreboard;
  logic [15:0] rot_lockout;
  logic [15:0] btn_lockout;
  logic [15:0] mask;
  logic [1:0]  last_phase;
  bit          primed;
  bit          pressed;
  logic [31:0] position;
  logic [31:0] turn_stamp;
  logic [31:0] press_stamp;
  qed_pkg::result_t due_results[$];
  int unsigned errors;

  function new();
    rot_lockout = qed_pkg::ROT_LOCKOUT_RST;
    btn_lockout = qed_pkg::BTN_LOCKOUT_RST;
    mask        = qed_pkg::TARGET_MASK_RST;
    last_phase  = 2'b00;
    primed      = 1'b0;
    pressed     = 1'b0;
    position    = '0;
    turn_stamp  = '0;
    press_stamp = '0;
    errors      = 0;
  endfunction

  function void set_register(logic [qed_pkg::CFG_IDX_W-1:0] idx,
                             logic [qed_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      qed_pkg::CFG_ROT_LOCKOUT: rot_lockout = val;
      qed_pkg::CFG_BTN_LOCKOUT: btn_lockout = val;
      qed_pkg::CFG_TARGET_MASK: mask = val;
      default: ;
    endcase
  endfunction

  // Place of a phase pair on the clockwise cycle 00, 01, 11, 10.
  function logic [1:0] ring_pos(logic [1:0] ph);
    return {ph[1], ph[1] ^ ph[0]};
  endfunction

  function void note_sample(qed_pkg::sample_t s);
    qed_pkg::result_t r;
    logic [1:0] ph;
    logic [1:0] delta;
    bit         want_pressed;
    ph           = {s.phase_a, s.phase_b};
    want_pressed = !s.button_level;
    r.turn_event  = qed_pkg::TURN_NONE;
    r.press_event = qed_pkg::PRESS_NONE;
    if (!primed) begin
      last_phase = ph;
      primed     = 1'b1;
    end else begin
      // A change inside the rotation lockout leaves the stored phase pair alone.
      if (ph != last_phase && (s.now_ms - turn_stamp) >= {16'd0, rot_lockout}) begin
        delta = ring_pos(ph) - ring_pos(last_phase);
        if (delta == 2'd1) begin
          position     = position + 32'd1;
          turn_stamp   = s.now_ms;
          r.turn_event = qed_pkg::TURN_CW;
        end else if (delta == 2'd3) begin
          position     = position - 32'd1;
          turn_stamp   = s.now_ms;
          r.turn_event = qed_pkg::TURN_CCW;
        end
        last_phase = ph;
      end
      if ((s.now_ms - press_stamp) >= {16'd0, btn_lockout} && want_pressed != pressed) begin
        pressed       = want_pressed;
        press_stamp   = s.now_ms;
        r.press_event = want_pressed ? qed_pkg::PRESS_PRESS : qed_pkg::PRESS_RELEASE;
      end
    end
    r.count      = position;
    r.held       = pressed;
    r.event_mask = mask;
    due_results.push_back(r);
  endfunction

  task report(string what);
    $display("MISMATCH: %s", what);
    errors++;
  endtask

  task check_result(qed_pkg::result_t got);
    qed_pkg::result_t want;
    if (due_results.size() == 0) begin
      report($sformatf("result item with nothing expected, count %0d", got.count));
      return;
    end
    want = due_results.pop_front();
    if (got.turn_event !== want.turn_event)
      report($sformatf("turn_event %0d, expected %0d", got.turn_event, want.turn_event));
    if (got.press_event !== want.press_event)
      report($sformatf("press_event %0d, expected %0d", got.press_event, want.press_event));
    if (got.count !== want.count)
      report($sformatf("count %0d, expected %0d", got.count, want.count));
    if (got.held !== want.held)
      report($sformatf("held %0b, expected %0b", got.held, want.held));
    if (got.event_mask !== want.event_mask)
      report($sformatf("event_mask %h, expected %h", got.event_mask, want.event_mask));
  endtask
endclass

module tb_quadrature_encoder_debounce;

  localparam logic [qed_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 250;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [qed_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [qed_pkg::CFG_DATA_W-1:0] cfg_data;

  qed_chan_if #(.T(qed_pkg::sample_t)) in_ch ();
  qed_chan_if #(.T(qed_pkg::result_t)) out_ch ();

  quadrature_encoder_debounce u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  encoder_scoreboard sb = new();

  int unsigned cycles = 0;
  int          hold_asks = 0;
  int          recv_idle_pct = 20;
  int          send_idle_pct = 20;
  logic [1:0]  walk_pos;
  logic [1:0]  walk_dir;
  logic        walk_btn;
  logic [31:0] walk_ms;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("quadrature_encoder_debounce verification failed");
      $finish;
    end
  end

  // Results are checked before the sample of the same edge is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if (in_ch.valid && in_ch.ready) sb.note_sample(in_ch.data);
    end
  end

  // Result consumer: random stall bursts, plus a long hold whenever one is asked for.
  initial begin
    int hold_left;
    int burst_left;
    int served;
    hold_left  = 0;
    burst_left = 0;
    served     = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != served) begin
        served    = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        burst_left = $urandom_range(1, 16) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input qed_pkg::sample_t s);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drive(input logic a, input logic b, input logic btn, input logic [31:0] ms);
    qed_pkg::sample_t s;
    s.phase_a      = a;
    s.phase_b      = b;
    s.button_level = btn;
    s.now_ms       = ms;
    send_sample(s);
  endtask

  // Stops the input and waits until every expected result item has arrived.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [qed_pkg::CFG_IDX_W-1:0] idx,
                           input logic [qed_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, val);
  endtask

  task automatic configure(input logic [15:0] rot, input logic [15:0] btn,
                           input logic [15:0] mask);
    write_reg(qed_pkg::CFG_ROT_LOCKOUT, rot);
    write_reg(qed_pkg::CFG_BTN_LOCKOUT, btn);
    write_reg(qed_pkg::CFG_TARGET_MASK, mask);
  endtask

  // Mostly legal Gray steps with a drifting direction, some jumps and repeats, and
  // time steps clustered around both lockouts so that each side of them is hit.
  task automatic run_walk(input int count);
    qed_pkg::sample_t s;
    int unsigned      pick;
    int unsigned      span;
    logic [31:0]      step_ms;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) walk_pos = walk_pos + walk_dir;
      else if (pick < 60) walk_pos = walk_pos + 2'd2;
      else if (pick >= 80) walk_pos = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0) walk_dir = 2'd0 - walk_dir;
      if ($urandom_range(0, 6) == 0) walk_btn = !walk_btn;
      span = (sb.rot_lockout > sb.btn_lockout) ? sb.rot_lockout : sb.btn_lockout;
      case ($urandom_range(0, 7))
        0: step_ms = 32'd0;
        1: step_ms = (sb.rot_lockout == 0) ? 32'd0 : $urandom_range(0, sb.rot_lockout - 1);
        2: step_ms = sb.rot_lockout;
        3: step_ms = (sb.btn_lockout == 0) ? 32'd0 : $urandom_range(0, sb.btn_lockout - 1);
        4: step_ms = sb.btn_lockout;
        5: step_ms = $urandom_range(1, 8);
        6: step_ms = $urandom_range(0, 2 * span + 20);
        default: step_ms = $urandom;
      endcase
      walk_ms = walk_ms + step_ms;
      s.phase_a      = walk_pos[1];
      s.phase_b      = walk_pos[1] ^ walk_pos[0];
      s.button_level = walk_btn;
      s.now_ms       = walk_ms;
      send_sample(s);
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    walk_pos = 2'd0;
    walk_dir = 2'd1;
    walk_btn = 1'b1;
    walk_ms  = $urandom;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed samples under the reset lockouts of 5 and 50.
    drive(1'b1, 1'b1, 1'b0, 32'd0);
    drive(1'b1, 1'b1, 1'b1, 32'd1);
    drive(1'b1, 1'b1, 1'b0, 32'd49);
    drive(1'b1, 1'b1, 1'b0, 32'd50);
    drive(1'b1, 1'b0, 1'b0, 32'd50);
    drive(1'b0, 1'b0, 1'b0, 32'd54);
    drive(1'b0, 1'b0, 1'b0, 32'd55);
    drive(1'b1, 1'b0, 1'b0, 32'd60);
    drive(1'b0, 1'b1, 1'b0, 32'd70);
    drive(1'b0, 1'b1, 1'b1, 32'd99);
    drive(1'b0, 1'b1, 1'b1, 32'd100);
    drive(1'b1, 1'b1, 1'b1, 32'd200);
    drive(1'b0, 1'b1, 1'b0, 32'hFFFF_FFF0);
    drive(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
    drive(1'b0, 1'b1, 1'b1, 32'h0000_0003);
    drive(1'b0, 1'b1, 1'b1, 32'h0000_0004);
    drive(1'b1, 1'b0, 1'b1, 32'h7FFF_FFFF);
    drive(1'b1, 1'b0, 1'b0, 32'h8000_0000);
    drive(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
    drain();

    // A write beyond the last register must change nothing.
    write_reg(CFG_SPARE_IDX, 16'hFFFF);
    run_walk(250);
    drain();

    // No lockouts at all; the consumer holds off while samples keep coming.
    configure(16'h0000, 16'h0000, 16'hFFFF);
    send_idle_pct = 0;
    hold_asks <= hold_asks + 1;
    run_walk(80);
    send_idle_pct = 25;
    run_walk(170);
    drain();

    configure(16'hFFFF, 16'hFFFF, 16'h0000);
    run_walk(250);
    drain();

    configure(16'($urandom_range(0, 20)), 16'($urandom_range(0, 120)), 16'($urandom));
    run_walk(120);
    drain();
    run_walk(130);
    drain();

    configure(16'($urandom_range(0, 40)), 16'($urandom_range(0, 200)), 16'($urandom));
    recv_idle_pct <= 50;
    send_idle_pct = 10;
    run_walk(250);
    drain();

    configure(16'd3, 16'd30, 16'($urandom));
    recv_idle_pct <= 5;
    send_idle_pct = 50;
    run_walk(200);
    drain();

    // Closing stretch at full rate on both sides.
    configure(qed_pkg::ROT_LOCKOUT_RST, qed_pkg::BTN_LOCKOUT_RST, 16'($urandom));
    recv_idle_pct <= 0;
    send_idle_pct = 0;
    run_walk(200);
    drain();

    if (sb.errors == 0) begin
      $display("quadrature_encoder_debounce verification clean");
    end else begin
      $display("quadrature_encoder_debounce verification failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+src
src/qed_pkg.sv
src/qed_chan_if.sv
src/qed_step.sv
src/quadrature_encoder_debounce.sv
src/qed_checker.sv
verif/tb_quadrature_encoder_debounce.sv
